// ===== rtl/ypvm_pkg.sv =====
// ----------------------------------------------------------------------------
// ypvm_pkg
// shared types, constants and tables for the yaw/pitch view matrix block
// ----------------------------------------------------------------------------
package ypvm_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;

    localparam logic signed [16:0] ANG_QUARTER  = 17'sd11520;
    localparam logic signed [17:0] ANG_FULL     = 18'sd46080;
    localparam logic signed [17:0] ANG_HALF     = 18'sd23040;
    localparam logic signed [17:0] ANG_3QUARTER = 18'sd34560;
    localparam logic signed [15:0] ONE_Q14      = 16'sd16384;
    localparam logic signed [27:0] GAIN_Q24     = 28'sd10188014;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YAW,
        ST_PITCH,
        ST_MUL,
        ST_DOT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic sel_pitch;
    } sc_ctl_t;

    typedef struct packed {
        logic              done;
        logic signed [15:0] s;
        logic signed [15:0] c;
    } sc_res_t;

    function automatic logic signed [22:0] atan_q16(input logic [4:0] i);
        logic signed [22:0] v;
        begin
            case (i)
                5'd0:  v = 23'sd2949120;
                5'd1:  v = 23'sd1740967;
                5'd2:  v = 23'sd919879;
                5'd3:  v = 23'sd466945;
                5'd4:  v = 23'sd234379;
                5'd5:  v = 23'sd117304;
                5'd6:  v = 23'sd58666;
                5'd7:  v = 23'sd29335;
                5'd8:  v = 23'sd14668;
                5'd9:  v = 23'sd7334;
                5'd10: v = 23'sd3667;
                5'd11: v = 23'sd1833;
                5'd12: v = 23'sd917;
                5'd13: v = 23'sd458;
                5'd14: v = 23'sd229;
                5'd15: v = 23'sd115;
                5'd16: v = 23'sd57;
                5'd17: v = 23'sd29;
                5'd18: v = 23'sd14;
                5'd19: v = 23'sd7;
                5'd20: v = 23'sd4;
                5'd21: v = 23'sd2;
                5'd22: v = 23'sd1;
                default: v = 23'sd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [15:0] round_q14(input logic signed [31:0] p);
        logic signed [31:0] t;
        begin
            t = (p + 32'sd8192) >>> 14;
            return t[15:0];
        end
    endfunction

endpackage

// ===== rtl/ypvm_if.sv =====
// ----------------------------------------------------------------------------
// ypvm_in_if / ypvm_out_if
// valid/ready request channels of the view matrix block
// ----------------------------------------------------------------------------
interface ypvm_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [16:0] yaw_deg;
    logic signed [16:0] pitch_deg;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    modport source (output valid, kind, yaw_deg, pitch_deg, pos_x, pos_y, pos_z,
                    input ready);
    modport sink (input valid, kind, yaw_deg, pitch_deg, pos_x, pos_y, pos_z,
                  output ready);
endinterface

interface ypvm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_y;
    logic signed [15:0] fwd_z;
    logic signed [33:0] trans_x;
    logic signed [33:0] trans_y;
    logic signed [33:0] trans_z;
    modport source (output valid, right_x, right_y, right_z, up_x, up_y, up_z,
                    fwd_x, fwd_y, fwd_z, trans_x, trans_y, trans_z, input ready);
    modport sink (input valid, right_x, right_y, right_z, up_x, up_y, up_z,
                  fwd_x, fwd_y, fwd_z, trans_x, trans_y, trans_z, output ready);
endinterface

// ===== rtl/ypvm_sincos.sv =====
// ----------------------------------------------------------------------------
// ypvm_sincos
// iterative cordic sine/cosine of a q9.7 degree angle, one step per cycle
// ----------------------------------------------------------------------------
module ypvm_sincos #(
    parameter int CORDIC_STEPS = ypvm_pkg::CORDIC_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ypvm_pkg::sc_ctl_t   ctl,
    input  logic signed [16:0]  angle,
    output ypvm_pkg::sc_res_t   res
);
    localparam int NSTEP = (CORDIC_STEPS < ypvm_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                               : ypvm_pkg::ATAN_LEN;

    logic               busy_reg, busy_next;
    logic [4:0]         step_reg, step_next;
    logic               neg_reg, neg_next;
    logic signed [27:0] x_reg, x_next;
    logic signed [27:0] y_reg, y_next;
    logic signed [24:0] z_reg, z_next;
    logic               done_reg, done_next;
    logic signed [15:0] s_reg, s_next;
    logic signed [15:0] c_reg, c_next;

    logic signed [17:0] r;
    logic signed [17:0] t;
    logic signed [27:0] xs, ys, xr, yr;

    // angles below -360 degrees need a second full turn
    always_comb
    begin
        r = {angle[16], angle};
        if (r < 18'sd0)
        begin
            r = r + ypvm_pkg::ANG_FULL;
        end
        if (r < 18'sd0)
        begin
            r = r + ypvm_pkg::ANG_FULL;
        end
        if (r >= ypvm_pkg::ANG_FULL)
        begin
            r = r - ypvm_pkg::ANG_FULL;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        done_next = 1'b0;
        s_next    = s_reg;
        c_next    = c_reg;
        t         = r;
        xs        = x_reg >>> step_reg;
        ys        = y_reg >>> step_reg;
        xr        = (x_reg + 28'sd512) >>> 10;
        yr        = (y_reg + 28'sd512) >>> 10;
        if (ctl.start)
        begin
            if (r == 18'sd0)
            begin
                s_next = 16'sd0;  c_next = ypvm_pkg::ONE_Q14; done_next = 1'b1;
            end
            else if (r == {ypvm_pkg::ANG_QUARTER[16], ypvm_pkg::ANG_QUARTER})
            begin
                s_next = ypvm_pkg::ONE_Q14; c_next = 16'sd0; done_next = 1'b1;
            end
            else if (r == ypvm_pkg::ANG_HALF)
            begin
                s_next = 16'sd0;  c_next = -ypvm_pkg::ONE_Q14; done_next = 1'b1;
            end
            else if (r == ypvm_pkg::ANG_3QUARTER)
            begin
                s_next = -ypvm_pkg::ONE_Q14; c_next = 16'sd0; done_next = 1'b1;
            end
            else
            begin
                neg_next = 1'b0;
                if (r < {ypvm_pkg::ANG_QUARTER[16], ypvm_pkg::ANG_QUARTER})
                begin
                    t = r;
                end
                else if (r < ypvm_pkg::ANG_3QUARTER)
                begin
                    t = r - ypvm_pkg::ANG_HALF;
                    neg_next = 1'b1;
                end
                else
                begin
                    t = r - ypvm_pkg::ANG_FULL;
                end
                z_next    = 25'(t) <<< 9;
                x_next    = ypvm_pkg::GAIN_Q24;
                y_next    = 28'sd0;
                step_next = 5'd0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (step_reg == 5'(NSTEP))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                c_next = (xr > 28'sd16384) ? ypvm_pkg::ONE_Q14 :
                         (xr < -28'sd16384) ? -ypvm_pkg::ONE_Q14 : xr[15:0];
                s_next = (yr > 28'sd16384) ? ypvm_pkg::ONE_Q14 :
                         (yr < -28'sd16384) ? -ypvm_pkg::ONE_Q14 : yr[15:0];
                if (neg_reg)
                begin
                    c_next = -c_next;
                    s_next = -s_next;
                end
            end
            else
            begin
                if (z_reg >= 25'sd0)
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - 25'(ypvm_pkg::atan_q16(step_reg));
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + 25'(ypvm_pkg::atan_q16(step_reg));
                end
                step_next = step_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        s_reg   <= s_next;
        c_reg   <= c_next;
    end

    assign res.done = done_reg;
    assign res.s    = s_reg;
    assign res.c    = c_reg;

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !ctl.start) else $error("start while busy");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg <= 5'(NSTEP)) else $error("step overrun");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done not a pulse");
`endif
endmodule

// ===== rtl/yaw_pitch_view_matrix_top.sv =====
// ----------------------------------------------------------------------------
// yaw_pitch_view_matrix_top
// camera state and look-at view basis from yaw, pitch and position
// ----------------------------------------------------------------------------
// usage:
//   req_in carries one request: kind 0 loads pos_x/y/z, kind 1 loads yaw
//   and pitch. each request yields one result on res_out: right, up and
//   forward in q1.14 and the view translation in q17.16.
//   the result comes from the shared cordic unit run for yaw then
//   pitch (an exact multiple of 90 degrees skips the iterations),
//   followed by one shared 16x16 multiplier for the basis products
//   and one 32x16 multiplier accumulating the nine dot product terms.
//   one request is in flight at a time; req_in.ready is low until the
//   result is taken and rises the cycle after. a stall on res_out holds
//   the result and the block.
//   reset sets yaw to -90 degrees, pitch and position to zero; no
//   result is pending after reset.
// ----------------------------------------------------------------------------
module yaw_pitch_view_matrix_top #(
    parameter int CORDIC_STEPS = ypvm_pkg::CORDIC_STEPS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    ypvm_in_if.sink      req_in,
    ypvm_out_if.source   res_out
);
    ypvm_pkg::state_t   state_reg, state_next;
    logic signed [16:0] yaw_reg, pitch_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [15:0] sy_reg, cy_reg, sp_reg, cp_reg;
    logic signed [15:0] r_reg [3];
    logic signed [15:0] u_reg [3];
    logic signed [15:0] f_reg [3];
    logic signed [47:0] acc_reg;
    logic signed [33:0] t_reg [3];
    logic [3:0]         cnt_reg, cnt_next;

    ypvm_pkg::sc_ctl_t  sc_ctl;
    ypvm_pkg::sc_res_t  sc_res;
    logic signed [16:0] sc_angle;

    logic signed [15:0] ma, mb;
    logic signed [31:0] mp;
    logic signed [15:0] mq;
    logic signed [15:0] da;
    logic signed [31:0] db;
    logic signed [47:0] dp;
    logic signed [47:0] dr;
    logic [1:0]         dv, de;
    logic               deg;

    assign deg = (cp_reg == 16'sd0);

    ypvm_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sc_ctl),
        .angle (sc_angle),
        .res   (sc_res)
    );

    assign sc_angle = sc_ctl.sel_pitch ? pitch_reg : yaw_reg;
    assign req_in.ready = (state_reg == ypvm_pkg::ST_IDLE);

    // basis products: 0 cy*cp, 1 sy*cp, 2 cy*sp, 3 sy*sp
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    begin ma = cy_reg; mb = cp_reg; end
            2'd1:    begin ma = sy_reg; mb = cp_reg; end
            2'd2:    begin ma = cy_reg; mb = sp_reg; end
            default: begin ma = sy_reg; mb = sp_reg; end
        endcase
        mp = ma * mb;
        mq = ypvm_pkg::round_q14(mp);
    end

    // dot terms: vector = cnt/3, element = cnt%3
    always_comb
    begin
        dv = 2'd0;
        de = 2'd0;
        case (cnt_reg)
            4'd0: begin dv = 2'd0; de = 2'd0; end
            4'd1: begin dv = 2'd0; de = 2'd1; end
            4'd2: begin dv = 2'd0; de = 2'd2; end
            4'd3: begin dv = 2'd1; de = 2'd0; end
            4'd4: begin dv = 2'd1; de = 2'd1; end
            4'd5: begin dv = 2'd1; de = 2'd2; end
            4'd6: begin dv = 2'd2; de = 2'd0; end
            4'd7: begin dv = 2'd2; de = 2'd1; end
            default: begin dv = 2'd2; de = 2'd2; end
        endcase
        case (dv)
            2'd0:    da = r_reg[de];
            2'd1:    da = u_reg[de];
            default: da = f_reg[de];
        endcase
        db = pos_reg[de];
        dp = 48'(da) * 48'(db);
        dr = (acc_reg + dp + 48'sd8192) >>> 14;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sc_ctl     = '0;
        unique case (state_reg)
            ypvm_pkg::ST_IDLE:
            begin
                if (req_in.valid)
                begin
                    state_next   = ypvm_pkg::ST_YAW;
                end
            end
            ypvm_pkg::ST_YAW:
            begin
                if (cnt_reg == 4'd0)
                begin
                    sc_ctl.start = 1'b1;
                    cnt_next = 4'd1;
                end
                else if (sc_res.done)
                begin
                    state_next = ypvm_pkg::ST_PITCH;
                    cnt_next   = 4'd0;
                end
            end
            ypvm_pkg::ST_PITCH:
            begin
                sc_ctl.sel_pitch = 1'b1;
                if (cnt_reg == 4'd0)
                begin
                    sc_ctl.start = 1'b1;
                    cnt_next = 4'd1;
                end
                else if (sc_res.done)
                begin
                    state_next = ypvm_pkg::ST_MUL;
                    cnt_next   = 4'd0;
                end
            end
            ypvm_pkg::ST_MUL:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd3)
                begin
                    state_next = ypvm_pkg::ST_DOT;
                    cnt_next   = 4'd0;
                end
            end
            ypvm_pkg::ST_DOT:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd8)
                begin
                    state_next = ypvm_pkg::ST_OUT;
                    cnt_next   = 4'd0;
                end
            end
            ypvm_pkg::ST_OUT:
            begin
                if (res_out.ready)
                begin
                    state_next = ypvm_pkg::ST_IDLE;
                end
            end
            default: state_next = ypvm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ypvm_pkg::ST_IDLE;
            cnt_reg   <= 4'd0;
            yaw_reg   <= -ypvm_pkg::ANG_QUARTER;
            pitch_reg <= 17'sd0;
            pos_reg[0] <= 32'sd0;
            pos_reg[1] <= 32'sd0;
            pos_reg[2] <= 32'sd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (req_in.valid && req_in.ready)
            begin
                if (req_in.kind)
                begin
                    yaw_reg   <= req_in.yaw_deg;
                    pitch_reg <= req_in.pitch_deg;
                end
                else
                begin
                    pos_reg[0] <= req_in.pos_x;
                    pos_reg[1] <= req_in.pos_y;
                    pos_reg[2] <= req_in.pos_z;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sc_res.done && state_reg == ypvm_pkg::ST_YAW)
        begin
            sy_reg <= sc_res.s;
            cy_reg <= sc_res.c;
        end
        if (sc_res.done && state_reg == ypvm_pkg::ST_PITCH)
        begin
            sp_reg <= sc_res.s;
            cp_reg <= sc_res.c;
        end
        if (state_reg == ypvm_pkg::ST_MUL)
        begin
            if (cnt_reg == 4'd0)
            begin
                f_reg[0] <= mq;
                f_reg[1] <= sp_reg;
                r_reg[1] <= 16'sd0;
                u_reg[1] <= deg ? 16'sd0 : (cp_reg[15] ? -cp_reg : cp_reg);
                r_reg[0] <= deg ? 16'sd0 : (cp_reg[15] ? sy_reg : -sy_reg);
                r_reg[2] <= deg ? 16'sd0 : (cp_reg[15] ? -cy_reg : cy_reg);
            end
            else if (cnt_reg == 4'd1)
            begin
                f_reg[2] <= mq;
            end
            else if (cnt_reg == 4'd2)
            begin
                u_reg[0] <= deg ? 16'sd0 : (cp_reg[15] ? mq : -mq);
            end
            else
            begin
                u_reg[2] <= deg ? 16'sd0 : (cp_reg[15] ? mq : -mq);
            end
            acc_reg <= 48'sd0;
        end
        if (state_reg == ypvm_pkg::ST_DOT)
        begin
            if (de == 2'd2)
            begin
                acc_reg <= 48'sd0;
                case (dv)
                    2'd0:    t_reg[0] <= -dr[33:0];
                    2'd1:    t_reg[1] <= -dr[33:0];
                    default: t_reg[2] <= dr[33:0];
                endcase
            end
            else
            begin
                acc_reg <= acc_reg + dp;
            end
        end
    end

    assign res_out.valid   = (state_reg == ypvm_pkg::ST_OUT);
    assign res_out.right_x = r_reg[0];
    assign res_out.right_y = r_reg[1];
    assign res_out.right_z = r_reg[2];
    assign res_out.up_x    = u_reg[0];
    assign res_out.up_y    = u_reg[1];
    assign res_out.up_z    = u_reg[2];
    assign res_out.fwd_x   = f_reg[0];
    assign res_out.fwd_y   = f_reg[1];
    assign res_out.fwd_z   = f_reg[2];
    assign res_out.trans_x = t_reg[0];
    assign res_out.trans_y = t_reg[1];
    assign res_out.trans_z = t_reg[2];

`ifndef SYNTHESIS
    a_ready_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_in.ready && res_out.valid)) else $error("ready during result");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && !res_out.ready) |=> res_out.valid)
        else $error("result dropped");
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_in.valid && req_in.ready) |=> state_reg == ypvm_pkg::ST_YAW)
        else $error("request not started");
`endif
endmodule
